// ===== design/ierb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ierb_pkg
// Shared types and constants for the ICMP echo reply builder.
// ----------------------------------------------------------------------------
package ierb_pkg;

   localparam int FRAME_BYTES_DEFAULT = 2048;
   localparam int REPLY_LEN_CAP       = 2047;

   localparam int ETH_HDR_LEN   = 14;
   localparam int MAC_LEN       = 6;
   localparam int IP_ADDR_LEN   = 4;
   localparam int IP_SRC_OFS    = ETH_HDR_LEN + 12;
   localparam int IP_DST_OFS    = ETH_HDR_LEN + 16;
   localparam int IP_LEN_HI_OFS = ETH_HDR_LEN + 2;
   localparam int IP_LEN_LO_OFS = ETH_HDR_LEN + 3;
   localparam int IP_PROTO_OFS  = ETH_HDR_LEN + 9;

   localparam logic [7:0] PROTO_ICMP    = 8'h01;
   localparam logic [7:0] ICMP_ECHO_REQ = 8'd8;

   typedef enum logic {
      FUNC_LOAD = 1'b0,
      FUNC_READ = 1'b1
   } func_type;

   typedef struct packed {
      func_type    func;
      logic [7:0]  data_byte;
      logic        last_byte;
      logic [10:0] read_index;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        is_ping_request;
      logic        frame_complete;
      logic [10:0] reply_length;
      logic        overflow;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ_WAIT,
      ST_RESPOND
   } state_type;

   typedef enum logic [1:0] {
      RD_SRC_DATA,
      RD_SRC_ZERO,
      RD_SRC_CHECK_HI,
      RD_SRC_CHECK_LO
   } rd_src_type;

   typedef struct packed {
      logic capture;
      logic load;
      logic read_issue;
      logic read_finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_read;
   } ctrl_status_type;

endpackage
`default_nettype wire

// ===== design/icmp_echo_reply_builder_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// icmp_echo_reply_builder_core
// Stores a received frame and serves the bytes of its ICMP echo reply.
// Sequence: a load passes the execute and respond states, a read passes
// execute, read wait and respond (the extra state covers the registered
// frame store read). Busy until the result strobe: a new request is taken
// only when idle. The result cannot be stalled by the receiver.
// Reset: synchronous, clears control and frame state; store contents are
// not cleared, and bytes not yet written never reach the output.
// ----------------------------------------------------------------------------
module icmp_echo_reply_builder_core #(
   parameter int FRAME_BYTES = ierb_pkg::FRAME_BYTES_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire ierb_pkg::req_type req_item,
   output logic                   busy,
   output logic                   rsp_valid,
   output ierb_pkg::rsp_type      rsp_item
);
   import ierb_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   ierb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   ierb_datapath #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .cmd      (cmd),
      .status   (status),
      .rsp_item (rsp_item)
   );

`ifndef ASSERT_OFF
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("request accepted but block not busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy && !cmd.capture)
      else $error("result strobe outside a request");

   a_len_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_item.reply_length) <= 32'(FRAME_BYTES - 1)))
      else $error("reply length beyond store");
`endif

endmodule
`default_nettype wire

// ===== design/ierb_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ierb_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ierb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== design/ierb_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ierb_ctrl
// Request sequencer: accept, execute, wait for store read (reads only), respond.
// ----------------------------------------------------------------------------
module ierb_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire ierb_pkg::ctrl_status_type status,
   output ierb_pkg::ctrl_cmd_type        cmd,
   output logic                          busy,
   output logic                          rsp_valid
);
   import ierb_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (start) state_in = ST_EXEC;
         ST_EXEC:      state_in = status.is_read ? ST_READ_WAIT : ST_RESPOND;
         ST_READ_WAIT: state_in = ST_RESPOND;
         ST_RESPOND:   state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy        = 1'b0;
            cmd.capture = start;
         end
         ST_EXEC: begin
            cmd.load       = !status.is_read;
            cmd.read_issue = status.is_read;
         end
         ST_READ_WAIT: begin
            cmd.read_finish = 1'b1;
         end
         ST_RESPOND: begin
            rsp_valid = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/ierb_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ierb_datapath
// Frame store, header capture, inline checksum and reply byte formation.
// ----------------------------------------------------------------------------
module ierb_datapath #(
   parameter int FRAME_BYTES = ierb_pkg::FRAME_BYTES_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ierb_pkg::req_type     req_item,
   input  wire ierb_pkg::ctrl_cmd_type cmd,
   output ierb_pkg::ctrl_status_type  status,
   output ierb_pkg::rsp_type          rsp_item
);
   import ierb_pkg::*;

   localparam int AW = $clog2(FRAME_BYTES);
   localparam int CW = $clog2(FRAME_BYTES + 1);
   localparam int LW = (CW > 17) ? CW : 17;
   localparam int IW = (CW > 11) ? CW : 11;

   localparam logic [CW-1:0] COUNT_FULL = CW'(FRAME_BYTES);
   localparam logic [16:0]   RL_MAX     =
      17'((FRAME_BYTES - 1 < REPLY_LEN_CAP) ? FRAME_BYTES - 1 : REPLY_LEN_CAP);

   req_type        req_ff;
   logic [CW-1:0]  byte_count_ff, byte_count_in;
   logic [5:0]     header_len_ff, header_len_in;
   logic [15:0]    ip_total_len_ff, ip_total_len_in;
   logic [7:0]     proto_ff, proto_in;
   logic [7:0]     type_ff, type_in;
   logic [16:0]    sum_acc_ff, sum_acc_in;
   logic [7:0]     high_hold_ff, high_hold_in;
   logic           high_pending_ff, high_pending_in;
   logic [15:0]    reply_check_ff, reply_check_in;
   logic           done_ff, done_in;
   logic           overflow_ff, overflow_in;
   logic [7:0]     out_byte_ff, out_byte_in;
   rd_src_type     rd_src_ff, rd_src_in;

   logic [CW-1:0]  bc_cur;
   logic [5:0]     hl_cur;
   logic [15:0]    tl_cur;
   logic [16:0]    sum_cur;
   logic [7:0]     hh_cur;
   logic           hp_cur;
   logic [LW-1:0]  pos_l, start_l, end_l, off_l;
   logic [7:0]     icmp_val;
   logic           add_en;
   logic [15:0]    add_word;
   logic [16:0]    add_raw, sum_new;

   logic           wr_en;
   logic [AW-1:0]  wr_addr;
   logic [AW-1:0]  rd_addr;
   logic [7:0]     rd_data;

   logic [IW-1:0]  r_w, s_w, bc_w;
   logic [10:0]    icmp_start;
   logic [16:0]    rl_sum;

   // load path
   always_comb begin
      bc_cur   = done_ff ? '0 : byte_count_ff;
      hl_cur   = done_ff ? '0 : header_len_ff;
      tl_cur   = done_ff ? '0 : ip_total_len_ff;
      sum_cur  = done_ff ? '0 : sum_acc_ff;
      hh_cur   = done_ff ? '0 : high_hold_ff;
      hp_cur   = done_ff ? 1'b0 : high_pending_ff;

      byte_count_in   = byte_count_ff;
      header_len_in   = header_len_ff;
      ip_total_len_in = ip_total_len_ff;
      proto_in        = proto_ff;
      type_in         = type_ff;
      sum_acc_in      = sum_acc_ff;
      high_hold_in    = high_hold_ff;
      high_pending_in = high_pending_ff;
      reply_check_in  = reply_check_ff;
      done_in         = done_ff;
      overflow_in     = overflow_ff;

      wr_en    = 1'b0;
      wr_addr  = bc_cur[AW-1:0];
      pos_l    = LW'(bc_cur);
      start_l  = '0;
      end_l    = '0;
      off_l    = '0;
      icmp_val = '0;
      add_en   = 1'b0;
      add_word = '0;
      add_raw  = '0;
      sum_new  = '0;

      if (cmd.load) begin
         byte_count_in   = bc_cur;
         header_len_in   = hl_cur;
         ip_total_len_in = tl_cur;
         proto_in        = done_ff ? '0 : proto_ff;
         type_in         = done_ff ? '0 : type_ff;
         sum_acc_in      = sum_cur;
         high_hold_in    = hh_cur;
         high_pending_in = hp_cur;
         reply_check_in  = done_ff ? '0 : reply_check_ff;
         done_in         = 1'b0;
         overflow_in     = done_ff ? 1'b0 : overflow_ff;

         if (bc_cur == COUNT_FULL) begin
            overflow_in = 1'b1;
         end else begin
            wr_en         = 1'b1;
            byte_count_in = bc_cur + CW'(1);
            if (pos_l == LW'(ETH_HDR_LEN))   header_len_in = {req_ff.data_byte[3:0], 2'b00};
            if (pos_l == LW'(IP_LEN_HI_OFS)) ip_total_len_in[15:8] = req_ff.data_byte;
            if (pos_l == LW'(IP_LEN_LO_OFS)) ip_total_len_in[7:0] = req_ff.data_byte;
            if (pos_l == LW'(IP_PROTO_OFS))  proto_in = req_ff.data_byte;
            start_l = LW'(ETH_HDR_LEN) + LW'(header_len_in);
            end_l   = LW'(ETH_HDR_LEN) + LW'(ip_total_len_in);
            if (pos_l == start_l) type_in = req_ff.data_byte;
            if (pos_l >= start_l && pos_l < end_l) begin
               off_l    = pos_l - start_l;
               icmp_val = (off_l == LW'(0) || off_l == LW'(2) || off_l == LW'(3))
                          ? 8'h00 : req_ff.data_byte;
               if (!off_l[0]) begin
                  high_hold_in    = icmp_val;
                  high_pending_in = 1'b1;
               end else begin
                  add_en          = 1'b1;
                  add_word        = {hh_cur, icmp_val};
                  high_pending_in = 1'b0;
               end
            end
         end

         // odd length: pad the held byte with a zero low byte
         if (req_ff.last_byte && !add_en && high_pending_in) begin
            add_en          = 1'b1;
            add_word        = {high_hold_in, 8'h00};
            high_pending_in = 1'b0;
         end

         add_raw = {1'b0, sum_cur[15:0]} + {1'b0, add_word};
         sum_new = {1'b0, add_raw[15:0]} + 17'(add_raw[16]);
         if (add_en) sum_acc_in = sum_new;

         if (req_ff.last_byte) begin
            reply_check_in = ~sum_acc_in[15:0];
            done_in        = 1'b1;
         end
      end
   end

   // read path: swap addresses, pick the byte source
   always_comb begin
      r_w        = IW'(req_ff.read_index);
      bc_w       = IW'(byte_count_ff);
      icmp_start = 11'(ETH_HDR_LEN) + 11'(header_len_ff);
      if (r_w < IW'(MAC_LEN)) begin
         s_w = r_w + IW'(MAC_LEN);
      end else if (r_w < IW'(2 * MAC_LEN)) begin
         s_w = r_w - IW'(MAC_LEN);
      end else if (r_w >= IW'(IP_SRC_OFS) && r_w < IW'(IP_SRC_OFS + IP_ADDR_LEN)) begin
         s_w = r_w + IW'(IP_ADDR_LEN);
      end else if (r_w >= IW'(IP_DST_OFS) && r_w < IW'(IP_DST_OFS + IP_ADDR_LEN)) begin
         s_w = r_w - IW'(IP_ADDR_LEN);
      end else begin
         s_w = r_w;
      end
      rd_addr = s_w[AW-1:0];

      if (r_w >= bc_w) begin
         rd_src_in = RD_SRC_ZERO;
      end else if (req_ff.read_index == icmp_start) begin
         rd_src_in = RD_SRC_ZERO;
      end else if (req_ff.read_index == icmp_start + 11'd2) begin
         rd_src_in = RD_SRC_CHECK_HI;
      end else if (req_ff.read_index == icmp_start + 11'd3) begin
         rd_src_in = RD_SRC_CHECK_LO;
      end else if (s_w >= bc_w) begin
         rd_src_in = RD_SRC_ZERO;
      end else begin
         rd_src_in = RD_SRC_DATA;
      end
   end

   always_comb begin
      out_byte_in = out_byte_ff;
      if (cmd.load) begin
         out_byte_in = 8'h00;
      end else if (cmd.read_finish) begin
         case (rd_src_ff)
            RD_SRC_DATA:     out_byte_in = rd_data;
            RD_SRC_ZERO:     out_byte_in = 8'h00;
            RD_SRC_CHECK_HI: out_byte_in = reply_check_ff[15:8];
            RD_SRC_CHECK_LO: out_byte_in = reply_check_ff[7:0];
            default:         out_byte_in = 8'h00;
         endcase
      end
   end

   ierb_ram #(
      .WIDTH (8),
      .DEPTH (FRAME_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_ff.data_byte),
      .rd_en   (cmd.read_issue),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req_item;
      if (cmd.read_issue) rd_src_ff <= rd_src_in;
      out_byte_ff <= out_byte_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff   <= '0;
         header_len_ff   <= '0;
         ip_total_len_ff <= '0;
         proto_ff        <= '0;
         type_ff         <= '0;
         sum_acc_ff      <= '0;
         high_hold_ff    <= '0;
         high_pending_ff <= 1'b0;
         reply_check_ff  <= '0;
         done_ff         <= 1'b0;
         overflow_ff     <= 1'b0;
      end else begin
         byte_count_ff   <= byte_count_in;
         header_len_ff   <= header_len_in;
         ip_total_len_ff <= ip_total_len_in;
         proto_ff        <= proto_in;
         type_ff         <= type_in;
         sum_acc_ff      <= sum_acc_in;
         high_hold_ff    <= high_hold_in;
         high_pending_ff <= high_pending_in;
         reply_check_ff  <= reply_check_in;
         done_ff         <= done_in;
         overflow_ff     <= overflow_in;
      end
   end

   assign rl_sum = 17'(ETH_HDR_LEN) + {1'b0, ip_total_len_ff};

   assign status.is_read = (req_ff.func == FUNC_READ);

   assign rsp_item.out_byte        = out_byte_ff;
   assign rsp_item.is_ping_request = (proto_ff == PROTO_ICMP) && (type_ff == ICMP_ECHO_REQ);
   assign rsp_item.frame_complete  = done_ff;
   assign rsp_item.reply_length    = (rl_sum > RL_MAX) ? RL_MAX[10:0] : rl_sum[10:0];
   assign rsp_item.overflow        = overflow_ff;

endmodule
`default_nettype wire
